/* src/mfq_pkg.sv */
`timescale 1ns / 1ps

package mfq_pkg;

  // Queue size and derived widths.
  localparam int CAPACITY = 64;
  localparam int VALUE_W = 64;
  localparam int COUNT_FIELD_W = 7;
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DEPTH_W = $clog2(CAPACITY + 1);
  localparam int TOTAL_W = DEPTH_W + 1;

  // Minimum reported for an empty queue: the largest signed 64-bit value.
  localparam logic signed [VALUE_W-1:0] MIN_EMPTY = {1'b0, {(VALUE_W - 1) {1'b1}}};

  // Request codes.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_POP_EMPTY = 2'd1,
    STATUS_PUSH_FULL = 2'd2
  } status_t;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_FIELD_W-1:0] count_t;

  // Signed minimum of two values.
  function automatic value_t smaller(input value_t a, input value_t b);
    return (b < a) ? b : a;
  endfunction

endpackage

/* src/mfq_req_if.sv */
`timescale 1ns / 1ps

// Request channel: one word is a push or a pop.
interface mfq_req_if;
  logic valid;
  logic ready;
  logic req_type;
  mfq_pkg::value_t value;

  modport source(output valid, output req_type, output value, input ready);
  modport sink(input valid, input req_type, input value, output ready);
endinterface

/* src/mfq_rsp_if.sv */
`timescale 1ns / 1ps

// Response channel: one word per request.
interface mfq_rsp_if;
  logic valid;
  logic ready;
  mfq_pkg::value_t window_min;
  mfq_pkg::count_t count;
  logic is_empty;
  mfq_pkg::status_t status;

  modport source(output valid, output window_min, output count, output is_empty,
                 output status, input ready);
  modport sink(input valid, input window_min, input count, input is_empty,
               input status, output ready);
endinterface

/* src/mfq_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module mfq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/min_fold_queue_core.sv */
`timescale 1ns / 1ps

// FIFO queue of up to CAPACITY signed 64-bit values that reports the minimum of
// its contents after every request, using a back stack for pushes and a front
// stack of suffix minima for pops. One request is taken at a time; the response
// sits in an output register, so the next request is accepted while it waits.
// A push, or any refused request, goes straight to the finish state. A pop that
// leaves entries on the front stack first reads the new top minimum from the
// front RAM; a pop that takes the last front entry goes straight to finish. A
// pop that finds the front stack empty first moves the back entries across,
// one at a time through the back RAM read port; the oldest is popped at once.
module min_fold_queue_core (
  input logic clk,
  input logic rst,
  mfq_req_if.sink req,
  mfq_rsp_if.source rsp
);
  import mfq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_XFER_RD  = 6'b000010,
    S_XFER_WR  = 6'b000100,
    S_TOP_RD   = 6'b001000,
    S_TOP_WAIT = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [DEPTH_W-1:0] front_depth;
  logic [DEPTH_W-1:0] back_depth;
  value_t front_top;
  value_t back_top;
  value_t run_min;
  status_t status_r;

  logic [TOTAL_W-1:0] total;
  logic [DEPTH_W-1:0] front_dec;
  logic [DEPTH_W-1:0] back_dec;
  logic accept;
  logic push_ok;

  // Front stack keeps suffix minima only; back stack keeps the pushed values.
  logic back_wr_en;
  logic back_rd_en;
  value_t back_rd_data;
  logic front_wr_en;
  logic front_rd_en;
  value_t front_rd_data;
  value_t xfer_min;

  assign total = TOTAL_W'(front_depth) + TOTAL_W'(back_depth);
  assign front_dec = front_depth - DEPTH_W'(1);
  assign back_dec = back_depth - DEPTH_W'(1);
  assign accept = req.valid && req.ready;
  assign push_ok = (total < TOTAL_W'(CAPACITY));
  assign req.ready = (state == S_IDLE);

  // Minimum carried while rebuilding the front stack.
  assign xfer_min = (front_depth == '0) ? back_rd_data : smaller(back_rd_data, run_min);

  assign back_wr_en = accept && (req.req_type == REQ_PUSH) && push_ok;
  assign back_rd_en = (state == S_XFER_RD);
  assign front_wr_en = (state == S_XFER_WR) && (back_depth != '0);
  assign front_rd_en = (state == S_TOP_RD);

  mfq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_back_ram (
    .clk(clk),
    .wr_en(back_wr_en),
    .wr_addr(back_depth[ADDR_W-1:0]),
    .wr_data(req.value),
    .rd_en(back_rd_en),
    .rd_addr(back_dec[ADDR_W-1:0]),
    .rd_data(back_rd_data)
  );

  mfq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_front_ram (
    .clk(clk),
    .wr_en(front_wr_en),
    .wr_addr(front_depth[ADDR_W-1:0]),
    .wr_data(xfer_min),
    .rd_en(front_rd_en),
    .rd_addr(front_dec[ADDR_W-1:0]),
    .rd_data(front_rd_data)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_PUSH || total == '0) begin
            state_next = S_FINISH;
          end else if (front_depth == '0) begin
            state_next = S_XFER_RD;
          end else if (front_dec != '0) begin
            state_next = S_TOP_RD;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_XFER_RD: begin
        state_next = S_XFER_WR;
      end
      S_XFER_WR: begin
        state_next = (back_depth == '0) ? S_FINISH : S_XFER_RD;
      end
      S_TOP_RD: begin
        state_next = S_TOP_WAIT;
      end
      S_TOP_WAIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front_depth <= '0;
      back_depth <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.req_type == REQ_PUSH) begin
              if (push_ok) begin
                back_depth <= back_depth + DEPTH_W'(1);
              end
            end else if (total != '0 && front_depth != '0) begin
              front_depth <= front_dec;
            end
          end
        end
        S_XFER_RD: begin
          back_depth <= back_dec;
        end
        S_XFER_WR: begin
          // The last entry moved is the oldest one and is popped at once.
          if (back_depth != '0) begin
            front_depth <= front_depth + DEPTH_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers: running minima and request status.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_PUSH) begin
            status_r <= push_ok ? STATUS_OK : STATUS_PUSH_FULL;
            if (push_ok) begin
              back_top <= (back_depth == '0) ? req.value : smaller(back_top, req.value);
            end
          end else begin
            status_r <= (total == '0) ? STATUS_POP_EMPTY : STATUS_OK;
          end
        end
      end
      S_XFER_WR: begin
        run_min <= xfer_min;
        if (back_depth == '0) begin
          front_top <= run_min;
        end
      end
      S_TOP_WAIT: begin
        front_top <= front_rd_data;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_FINISH && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!rsp.valid || rsp.ready)) begin
      if (front_depth == '0 && back_depth == '0) begin
        rsp.window_min <= MIN_EMPTY;
      end else if (front_depth == '0) begin
        rsp.window_min <= back_top;
      end else if (back_depth == '0) begin
        rsp.window_min <= front_top;
      end else begin
        rsp.window_min <= smaller(front_top, back_top);
      end
      rsp.count <= COUNT_FIELD_W'(total);
      rsp.is_empty <= (total == '0);
      rsp.status <= status_r;
    end
  end

endmodule

/* src/mfq_checker.sv */
`timescale 1ns / 1ps

// Port-level checks on the response channel.
module mfq_checker (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input mfq_pkg::value_t window_min,
  input mfq_pkg::count_t count,
  input logic is_empty,
  input mfq_pkg::status_t status
);
  import mfq_pkg::*;

  // A stalled response word holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(window_min) && $stable(count)
      && $stable(status))
    else $error("response word changed while stalled");

  // The empty flag agrees with the count.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

  // An empty queue reports the largest value as its minimum.
  a_empty_min: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> window_min == MIN_EMPTY)
    else $error("empty queue reports a wrong minimum");

  // A refused pop only happens on an empty queue.
  a_pop_refused: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STATUS_POP_EMPTY |-> is_empty)
    else $error("pop refused on a non-empty queue");

  // A refused push only happens on a full queue.
  a_push_refused: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STATUS_PUSH_FULL |-> count == COUNT_FIELD_W'(CAPACITY))
    else $error("push refused on a queue that is not full");

endmodule

bind min_fold_queue_core mfq_checker u_mfq_checker (
  .clk(clk),
  .rst(rst),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .window_min(rsp.window_min),
  .count(rsp.count),
  .is_empty(rsp.is_empty),
  .status(rsp.status)
);
